/* hdl/adfa_pkg.sv */
// ----------------------------------------------------------------------------
// adfa_pkg
// Shared types and codes for the actuator delay timer with feedback alarm.
// ----------------------------------------------------------------------------
package adfa_pkg;

    localparam int TIMER_W  = 32;
    localparam int CYCLE_W  = 24;
    localparam int FBTYPE_W = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ON_DELAY    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_DELAY   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_DELAY = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FB_TYPE     = 8'd3;

    // feedback type codes
    localparam logic [FBTYPE_W-1:0] FB_NONE        = 8'd0;
    localparam logic [FBTYPE_W-1:0] FB_OFF         = 8'd1;
    localparam logic [FBTYPE_W-1:0] FB_OFF_WHEN_OFF = 8'd2;
    localparam logic [FBTYPE_W-1:0] FB_ON          = 8'd3;

    typedef struct packed {
        logic [TIMER_W-1:0]  on_delay_us;
        logic [TIMER_W-1:0]  off_delay_us;
        logic [TIMER_W-1:0]  alarm_delay_us;
        logic [FBTYPE_W-1:0] feedback_type;
    } adfa_cfg_t;

    typedef struct packed {
        logic               command_on;
        logic               feedback_bit;
        logic [CYCLE_W-1:0] cycle_time_us;
    } adfa_item_t;

    typedef struct packed {
        logic drive_out;
        logic alarm_flag;
        logic rise_pulse;
        logic fall_pulse;
        logic feedback_on_state;
    } adfa_result_t;

endpackage

/* hdl/adfa_cfg_regs.sv */
// ----------------------------------------------------------------------------
// adfa_cfg_regs
// Configuration register file: delays and feedback type, written by index.
// ----------------------------------------------------------------------------
module adfa_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [adfa_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [adfa_pkg::CFG_DATA_W-1:0]   wr_data,
    output adfa_pkg::adfa_cfg_t               cfg
);

    adfa_pkg::adfa_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                adfa_pkg::REG_ON_DELAY:    cfg_reg.on_delay_us    <= wr_data;
                adfa_pkg::REG_OFF_DELAY:   cfg_reg.off_delay_us   <= wr_data;
                adfa_pkg::REG_ALARM_DELAY: cfg_reg.alarm_delay_us <= wr_data;
                adfa_pkg::REG_FB_TYPE:
                    cfg_reg.feedback_type <= wr_data[adfa_pkg::FBTYPE_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/adfa_core.sv */
// ----------------------------------------------------------------------------
// adfa_core
// Timer state and single-pass update for one control cycle.
// ----------------------------------------------------------------------------
module adfa_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  adfa_pkg::adfa_item_t item,
    input  adfa_pkg::adfa_cfg_t  cfg,
    output adfa_pkg::adfa_result_t result
);

    localparam int TW = adfa_pkg::TIMER_W;

    logic          drive_reg, drive_next;
    logic          alarm_reg, alarm_next;
    logic          rise_reg,  rise_next;
    logic          fall_reg,  fall_next;
    logic [TW-1:0] delay_timer_reg, delay_timer_next;
    logic [TW-1:0] alarm_timer_reg, alarm_timer_next;

    logic          fon;
    logic [TW:0]   delay_sum;
    logic [TW:0]   alarm_sum;
    logic [TW-1:0] delay_sat;
    logic [TW-1:0] alarm_sat;

    always_comb
    begin
        case (cfg.feedback_type)
            adfa_pkg::FB_NONE:         fon = item.command_on;
            adfa_pkg::FB_OFF:          fon = ~item.feedback_bit ^ drive_reg;
            adfa_pkg::FB_OFF_WHEN_OFF: fon = ~item.feedback_bit & ~drive_reg;
            adfa_pkg::FB_ON:           fon = item.feedback_bit ^ drive_reg;
            default:                   fon = ~item.command_on;
        endcase
    end

    // saturating adds of the cycle time onto both timers
    assign delay_sum = {1'b0, delay_timer_reg} + {{(TW + 1 - adfa_pkg::CYCLE_W){1'b0}},
                                                  item.cycle_time_us};
    assign alarm_sum = {1'b0, alarm_timer_reg} + {{(TW + 1 - adfa_pkg::CYCLE_W){1'b0}},
                                                  item.cycle_time_us};
    assign delay_sat = delay_sum[TW] ? {TW{1'b1}} : delay_sum[TW-1:0];
    assign alarm_sat = alarm_sum[TW] ? {TW{1'b1}} : alarm_sum[TW-1:0];

    always_comb
    begin
        alarm_next       = 1'b0;
        alarm_timer_next = '0;
        if (fon != item.command_on)
        begin
            alarm_next       = alarm_reg | (alarm_timer_reg > cfg.alarm_delay_us);
            alarm_timer_next = alarm_sat;
        end

        drive_next       = drive_reg;
        rise_next        = rise_reg;
        fall_next        = fall_reg;
        delay_timer_next = delay_timer_reg;
        if (!item.command_on && drive_reg)
        begin
            if (delay_timer_reg >= cfg.off_delay_us)
            begin
                drive_next = 1'b0;
                fall_next  = 1'b1;
            end
            else
            begin
                delay_timer_next = delay_sat;
            end
        end
        else if (item.command_on && !drive_reg)
        begin
            // advance first, then compare the new count
            delay_timer_next = delay_sat;
            if (delay_sat >= cfg.on_delay_us)
            begin
                drive_next = 1'b1;
                rise_next  = 1'b1;
            end
        end
        else
        begin
            drive_next       = item.command_on;
            rise_next        = 1'b0;
            fall_next        = 1'b0;
            delay_timer_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg       <= 1'b0;
            alarm_reg       <= 1'b0;
            rise_reg        <= 1'b0;
            fall_reg        <= 1'b0;
            delay_timer_reg <= '0;
            alarm_timer_reg <= '0;
        end
        else if (step)
        begin
            drive_reg       <= drive_next;
            alarm_reg       <= alarm_next;
            rise_reg        <= rise_next;
            fall_reg        <= fall_next;
            delay_timer_reg <= delay_timer_next;
            alarm_timer_reg <= alarm_timer_next;
        end
    end

    always_comb
    begin
        result.drive_out         = drive_next;
        result.alarm_flag        = alarm_next;
        result.rise_pulse        = rise_next;
        result.fall_pulse        = fall_next;
        result.feedback_on_state = fon;
    end

endmodule

/* hdl/actuator_delay_feedback_alarm.sv */
// ----------------------------------------------------------------------------
// actuator_delay_feedback_alarm
// On/off delay timer for an actuator drive with a feedback disagreement alarm.
//
// Each input transfer is one control cycle (command, feedback, cycle time).
// Each one yields exactly one result transfer with drive, alarm, pulses and
// the feedback-derived on-state. The cfg channel writes delays and feedback
// type by index; cfg_ready is always high and writes beyond index 3 are
// dropped. Write configuration only while no transfer is in flight.
// The input item is registered, the update of the timer state sits between the
// input register and the result register, and out_valid rises once the result
// register is loaded. One transfer per cycle while the receiver does not stall;
// a stalled result register holds up the update of the timer state.
// Reset clears all timers, flags and configuration and empties the pipe.
// When the receiver stalls the result register holds, the input register
// holds the next item, and in_ready falls once both are full.
// ----------------------------------------------------------------------------
module actuator_delay_feedback_alarm (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [adfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [adfa_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            command_on,
    input  logic                            feedback_bit,
    input  logic [adfa_pkg::CYCLE_W-1:0]    cycle_time_us,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            drive_out,
    output logic                            alarm_flag,
    output logic                            rise_pulse,
    output logic                            fall_pulse,
    output logic                            feedback_on_state
);

    adfa_pkg::adfa_cfg_t    cfg;
    adfa_pkg::adfa_item_t   item_reg;
    adfa_pkg::adfa_result_t result;
    adfa_pkg::adfa_result_t result_reg;
    logic                   in_vld_reg;
    logic                   out_vld_reg;
    logic                   step;
    logic                   in_xfer;

    assign cfg_ready = 1'b1;

    adfa_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // advance the state when an item is held and the result register is free or being drained
    assign step     = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || step;
    assign in_xfer  = in_valid && in_ready;

    adfa_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (step)
            begin
                in_vld_reg <= 1'b0;
            end

            if (step)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.command_on    <= command_on;
            item_reg.feedback_bit  <= feedback_bit;
            item_reg.cycle_time_us <= cycle_time_us;
        end
        if (step)
        begin
            result_reg <= result;
        end
    end

    assign out_valid         = out_vld_reg;
    assign drive_out         = result_reg.drive_out;
    assign alarm_flag        = result_reg.alarm_flag;
    assign rise_pulse        = result_reg.rise_pulse;
    assign fall_pulse        = result_reg.fall_pulse;
    assign feedback_on_state = result_reg.feedback_on_state;

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the actuator delay timer with feedback alarm.
//
// A shadow model of the timers, flags and configuration predicts one result
// per input transfer. A monitor compares every result transfer, field by
// field, against the oldest prediction. Directed tests cover each feedback
// type, the on/off delays with pulse holding and timer saturation. Random
// phases then run under several settings, with idle gaps on both channels
// and long receiver hold-offs that fill the pipe.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TW = adfa_pkg::TIMER_W;
    localparam int CW = adfa_pkg::CYCLE_W;
    localparam int FW = adfa_pkg::FBTYPE_W;
    localparam int IW = adfa_pkg::CFG_IDX_W;
    localparam int DW = adfa_pkg::CFG_DATA_W;

    logic          clk           = 1'b0;
    logic          rst_n         = 1'b0;
    logic          cfg_valid     = 1'b0;
    logic          cfg_ready;
    logic [IW-1:0] cfg_index     = '0;
    logic [DW-1:0] cfg_data      = '0;
    logic          in_valid      = 1'b0;
    logic          in_ready;
    logic          command_on    = 1'b0;
    logic          feedback_bit  = 1'b0;
    logic [CW-1:0] cycle_time_us = '0;
    logic          out_valid;
    logic          out_ready     = 1'b0;
    logic          drive_out;
    logic          alarm_flag;
    logic          rise_pulse;
    logic          fall_pulse;
    logic          feedback_on_state;

    actuator_delay_feedback_alarm dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .command_on        (command_on),
        .feedback_bit      (feedback_bit),
        .cycle_time_us     (cycle_time_us),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .drive_out         (drive_out),
        .alarm_flag        (alarm_flag),
        .rise_pulse        (rise_pulse),
        .fall_pulse        (fall_pulse),
        .feedback_on_state (feedback_on_state)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // shadow configuration
    logic [TW-1:0] on_dly    = '0;
    logic [TW-1:0] off_dly   = '0;
    logic [TW-1:0] alarm_dly = '0;
    logic [FW-1:0] fb_type   = adfa_pkg::FB_NONE;

    // shadow state
    logic          drv_q   = 1'b0;
    logic          alm_q   = 1'b0;
    logic          rise_q  = 1'b0;
    logic          fall_q  = 1'b0;
    logic [TW-1:0] dly_cnt = '0;
    logic [TW-1:0] alm_cnt = '0;

    adfa_pkg::adfa_result_t expected_results[$];
    int           errors     = 0;
    bit           tx_idle_en = 1'b0;
    bit           rx_idle_en = 1'b0;
    int           rx_hold    = 0;

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
                                              input logic [CW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {{(TW + 1 - CW){1'b0}}, b};
        return s[TW] ? {TW{1'b1}} : s[TW-1:0];
    endfunction

    // Advance the shadow timers by one control cycle and form its result.
    function automatic adfa_pkg::adfa_result_t step_actuator(input adfa_pkg::adfa_item_t it);
        adfa_pkg::adfa_result_t r;
        logic         d;
        logic         fon;
        d = drv_q;
        case (fb_type)
            adfa_pkg::FB_NONE:         fon = it.command_on;
            adfa_pkg::FB_OFF:          fon = !it.feedback_bit ^ d;
            adfa_pkg::FB_OFF_WHEN_OFF: fon = !it.feedback_bit && !d;
            adfa_pkg::FB_ON:           fon = it.feedback_bit ^ d;
            default:                   fon = !it.command_on;
        endcase

        if (fon != it.command_on)
        begin
            if (alm_cnt > alarm_dly)
                alm_q = 1'b1;
            alm_cnt = sat_add(alm_cnt, it.cycle_time_us);
        end
        else
        begin
            alm_q   = 1'b0;
            alm_cnt = '0;
        end

        if (!it.command_on && d)
        begin
            if (dly_cnt >= off_dly)
            begin
                drv_q  = 1'b0;
                fall_q = 1'b1;
            end
            else
                dly_cnt = sat_add(dly_cnt, it.cycle_time_us);
        end
        else if (it.command_on && !d)
        begin
            dly_cnt = sat_add(dly_cnt, it.cycle_time_us);
            if (dly_cnt >= on_dly)
            begin
                drv_q  = 1'b1;
                rise_q = 1'b1;
            end
        end
        else
        begin
            rise_q  = 1'b0;
            fall_q  = 1'b0;
            drv_q   = it.command_on;
            dly_cnt = '0;
        end

        r.drive_out         = drv_q;
        r.alarm_flag        = alm_q;
        r.rise_pulse        = rise_q;
        r.fall_pulse        = fall_q;
        r.feedback_on_state = fon;
        return r;
    endfunction

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0b, actual %0b", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare each result transfer first, then predict for each input transfer.
    always @(posedge clk)
    begin
        adfa_pkg::adfa_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected, actual %b", $time,
                         {drive_out, alarm_flag, rise_pulse, fall_pulse, feedback_on_state});
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("drive_out", want.drive_out, drive_out);
                check_field("alarm_flag", want.alarm_flag, alarm_flag);
                check_field("rise_pulse", want.rise_pulse, rise_pulse);
                check_field("fall_pulse", want.fall_pulse, fall_pulse);
                check_field("feedback_on_state", want.feedback_on_state, feedback_on_state);
            end
        end
        if (rst_n && in_valid && in_ready)
            expected_results.push_back(step_actuator(
                adfa_pkg::adfa_item_t'({command_on, feedback_bit, cycle_time_us})));
    end

    // Mostly short idle stretches, a few long ones.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic int pick_gap(input bit en);
        if (!en || $urandom_range(0, 99) < 55)
            return 0;
        return idle_len();
    endfunction

    // Receiver: honor a requested hold-off, else stall at random.
    initial
    begin
        forever
        begin
            if (rx_hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            else if (rx_idle_en && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat (idle_len()) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    function automatic adfa_pkg::adfa_item_t make_item(input logic cmd, input logic fb,
                                                       input logic [CW-1:0] dt);
        adfa_pkg::adfa_item_t it;
        it.command_on    = cmd;
        it.feedback_bit  = fb;
        it.cycle_time_us = dt;
        return it;
    endfunction

    task automatic send_item(input adfa_pkg::adfa_item_t it);
        int gap;
        gap = pick_gap(tx_idle_en);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        command_on    <= it.command_on;
        feedback_bit  <= it.feedback_bit;
        cycle_time_us <= it.cycle_time_us;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Drop valid and wait until every predicted result has been checked.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx,
                             input logic [DW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            adfa_pkg::REG_ON_DELAY:    on_dly    = data;
            adfa_pkg::REG_OFF_DELAY:   off_dly   = data;
            adfa_pkg::REG_ALARM_DELAY: alarm_dly = data;
            adfa_pkg::REG_FB_TYPE:     fb_type   = data[FW-1:0];
            default:                   ;
        endcase
    endtask

    // Write all registers, junk in the unused type bits, plus a stray index.
    task automatic set_config(input logic [TW-1:0] on_d, input logic [TW-1:0] off_d,
                              input logic [TW-1:0] alarm_d,
                              input logic [FW-1:0] fbt);
        logic [DW-1:0] junk;
        junk = $urandom();
        write_reg(adfa_pkg::REG_ON_DELAY, on_d);
        write_reg(adfa_pkg::REG_OFF_DELAY, off_d);
        write_reg(adfa_pkg::REG_ALARM_DELAY, alarm_d);
        write_reg(adfa_pkg::REG_FB_TYPE, {junk[DW-1:FW], fbt});
        write_reg(IW'($urandom_range(4, 255)), $urandom());
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [TW-1:0] rand_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        if (r < 25)
            return '1;
        if (r < 35)
            return $urandom();
        return $urandom_range(0, 3000);
    endfunction

    function automatic logic [FW-1:0] rand_fb_type();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return FW'($urandom_range(4, 255));
        case (r % 4)
            0:       return adfa_pkg::FB_NONE;
            1:       return adfa_pkg::FB_OFF;
            2:       return adfa_pkg::FB_OFF_WHEN_OFF;
            default: return adfa_pkg::FB_ON;
        endcase
    endfunction

    // Held command and feedback runs with random timing, plus some noise.
    task automatic run_random(input int n, input int dt_scale);
        logic          cmd_cur;
        logic          fb_cur;
        int            cmd_left;
        int            fb_left;
        int            r;
        logic [CW-1:0] dt;
        cmd_cur  = 1'b0;
        fb_cur   = 1'b0;
        cmd_left = 0;
        fb_left  = 0;
        repeat (n)
        begin
            if (cmd_left == 0)
            begin
                cmd_cur  = 1'($urandom_range(0, 1));
                cmd_left = $urandom_range(1, 10);
            end
            if (fb_left == 0)
            begin
                fb_cur  = 1'($urandom_range(0, 1));
                fb_left = $urandom_range(1, 8);
            end
            cmd_left--;
            fb_left--;
            r = $urandom_range(0, 99);
            if (r < 10)
                dt = '0;
            else if (r < 15)
                dt = '1;
            else if (r < 25)
                dt = CW'($urandom());
            else
                dt = CW'($urandom_range(0, dt_scale));
            if ($urandom_range(0, 9) == 0)
                send_item(make_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    CW'($urandom())));
            else
                send_item(make_item(cmd_cur, fb_cur, dt));
        end
    endtask

    // Each feedback type over all four combinations of feedback and drive.
    task automatic test_feedback_types();
        logic [FW-1:0] types[5];
        types = '{adfa_pkg::FB_NONE, adfa_pkg::FB_OFF, adfa_pkg::FB_OFF_WHEN_OFF,
                  adfa_pkg::FB_ON, 8'hFF};
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        foreach (types[i])
        begin
            drain();
            set_config('0, '0, '0, types[i]);
            send_item(make_item(1'b1, 1'b0, '0));
            send_item(make_item(1'b1, 1'b1, '1));
            send_item(make_item(1'b0, 1'b0, '1));
            send_item(make_item(1'b0, 1'b1, '0));
        end
    endtask

    // On/off delays, equality at the limit, pulse holding and reversal.
    task automatic test_delays_and_pulses();
        drain();
        set_config(32'd100, 32'd50, 32'd30, adfa_pkg::FB_ON);
        send_item(make_item(1'b1, 1'b0, 24'd40));
        send_item(make_item(1'b1, 1'b0, 24'd40));
        send_item(make_item(1'b1, 1'b0, 24'd40));
        send_item(make_item(1'b0, 1'b1, 24'd10));
        send_item(make_item(1'b0, 1'b0, 24'd10));
        send_item(make_item(1'b1, 1'b1, 24'd100));
        send_item(make_item(1'b0, 1'b1, 24'd25));
        send_item(make_item(1'b0, 1'b1, 24'd25));
        send_item(make_item(1'b0, 1'b0, 24'd0));
    endtask

    // Drive both timers into saturation with near-maximum cycle times.
    task automatic test_timer_saturation();
        drain();
        set_config('1, '1, 32'hFFFF_FFFE, 8'hA5);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (290)
            send_item(make_item(1'b1, 1'($urandom_range(0, 1)),
                                CW'($urandom_range(24'hF00000, 24'hFFFFFF))));
        repeat (6)
            send_item(make_item(1'b0, 1'($urandom_range(0, 1)), CW'($urandom())));
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 6; p++)
        begin
            drain();
            case (p)
                0:       set_config('0, '0, '0, adfa_pkg::FB_NONE);
                1:       set_config('1, '1, '1, 8'hFF);
                default: set_config(rand_delay(), rand_delay(), rand_delay(), rand_fb_type());
            endcase
            // one phase runs back to back with no idling
            tx_idle_en = (p != 3);
            rx_idle_en = (p != 3);
            run_random(200, 1000);
        end
    endtask

    // Hold the receiver off so the pipe fills and the input stalls.
    task automatic test_backpressure();
        drain();
        set_config($urandom_range(0, 2000), $urandom_range(0, 2000),
                   $urandom_range(0, 2000), rand_fb_type());
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        rx_hold    = 80;
        run_random(100, 800);
        drain();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        rx_hold    = 60;
        run_random(100, 800);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_feedback_types();
        test_delays_and_pulses();
        test_timer_saturation();
        test_random_settings();
        test_backpressure();

        drain();
        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            errors++;
        end
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("%0t: timeout", $time);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
hdl/adfa_pkg.sv
hdl/adfa_cfg_regs.sv
hdl/adfa_core.sv
hdl/actuator_delay_feedback_alarm.sv
sim/testbench.sv
